// ===== design/sgm_pkg.sv =====
// Shared types and constants for the single-star glob matcher.
// Used by every module in the design folder; depends on nothing else.
`timescale 1ns / 1ps

package sgm_pkg;

  localparam int SYM_W = 8;
  localparam int LEN_W = 8;
  localparam int GRP_W = 16;
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PW = $clog2(OUT_DEPTH);
  localparam int OUT_CW = $clog2(OUT_DEPTH + 1);

  localparam logic [SYM_W-1:0] STAR_BYTE = 8'd42;
  localparam logic [LEN_W-1:0] NAME_LEN_MAX = 8'd255;

  localparam logic MODE_PATTERN = 1'b0;
  localparam logic MODE_NAME = 1'b1;

  typedef logic [SYM_W-1:0] sym_t;

  typedef struct packed {
    logic pat_shift;
    logic name_shift;
    logic capture;
  } cell_ctrl_t;

endpackage

// ===== design/sgm_cell.sv =====
// One window cell: holds one reversed pattern byte and one recent name byte.
// Both bytes shift to the next cell; depends on sgm_pkg.
`timescale 1ns / 1ps

module sgm_cell import sgm_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  sym_t       pat_in,
  input  sym_t       name_in,
  input  logic       active,
  output sym_t       pat_out,
  output sym_t       name_out,
  output logic       ok
);

  sym_t pat;
  sym_t name;

  always_ff @(posedge clk) begin
    if (ctrl.pat_shift) begin
      pat <= pat_in;
    end
    if (ctrl.name_shift) begin
      name <= name_in;
    end
    if (ctrl.capture) begin
      ok <= (pat == name) || !active;
    end
  end

  assign pat_out = pat;
  assign name_out = name;

endmodule

// ===== design/sgm_out_fifo.sv =====
// Result buffer between the compare pipeline and the output channel.
// Small register FIFO of match bits; depends on sgm_pkg.
`timescale 1ns / 1ps

module sgm_out_fifo import sgm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic              wr_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              match,
  output logic [OUT_CW-1:0] count
);

  logic [OUT_DEPTH-1:0] store;
  logic [OUT_PW-1:0]    wr_ptr;
  logic [OUT_PW-1:0]    rd_ptr;
  logic                 pop;

  assign out_valid = (count != '0);
  assign match = store[rd_ptr];
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + OUT_PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OUT_PW'(1);
      end
      count <= count + OUT_CW'(wr_en) - OUT_CW'(pop);
    end
  end

endmodule

// ===== design/single_star_glob_matcher_core.sv =====
// Single-star glob matcher: one character per cycle, back to back, while in_ready is high.
// The match bit of a name is registered through the compare stages after its last character is
// accepted (window compare, group reduce, final reduce into the result FIFO).
// Throughput is one transaction per cycle while the output side keeps up.
// Reset clears the pattern and name control state; the pattern store and the
// character window are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module single_star_glob_matcher_core import sgm_pkg::*; #(
  parameter int MAX_PATTERN = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic [7:0] symbol,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       match
);

  localparam int AW = $clog2(MAX_PATTERN);
  localparam int PW = $clog2(MAX_PATTERN + 1);
  localparam int NG = (MAX_PATTERN + GRP_W - 1) / GRP_W;

  sym_t pat_mem [MAX_PATTERN];

  logic [PW-1:0]    plen;
  logic [AW-1:0]    star_pos;
  logic             star_found;
  logic             pattern_open;
  logic [LEN_W-1:0] name_len;
  logic             prefix_ok;
  logic             chk;
  logic             chk_last;
  sym_t             chk_sym;
  sym_t             chk_ref;

  logic             s1_valid;
  logic             s1_pref;
  logic             s1_len_ok;
  logic [PW-1:0]    s1_suf;
  logic             s2_valid;
  logic             s2_base;
  logic             s3_valid;
  logic             s3_base;
  logic [NG-1:0]    grp_ok;

  logic             acc;
  logic             pat_acc;
  logic             name_acc;
  logic [PW-1:0]    plen_base;
  logic             star_base;
  logic             store_en;
  logic [AW-1:0]    pfx_len;
  logic [PW-1:0]    suf_len;
  logic [LEN_W-1:0] min_len;
  logic [LEN_W-1:0] name_len_inc;
  logic             pfx_check;
  logic             mismatch;
  logic             prefix_ok_eff;
  logic [OUT_CW-1:0] fifo_count;
  logic [OUT_CW-1:0] occupancy;

  cell_ctrl_t              cell_ctrl;
  sym_t                    pat_chain  [MAX_PATTERN];
  sym_t                    name_chain [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]  cell_ok;
  logic [NG*GRP_W-1:0]     ok_pad;

  assign occupancy = fifo_count + OUT_CW'(s1_valid) + OUT_CW'(s2_valid) + OUT_CW'(s3_valid);
  assign in_ready = (occupancy < OUT_CW'(OUT_DEPTH));
  assign acc = in_valid && in_ready;
  assign pat_acc = acc && (mode == MODE_PATTERN);
  assign name_acc = acc && (mode == MODE_NAME);

  assign plen_base = pattern_open ? plen : '0;
  assign star_base = pattern_open && star_found;
  assign store_en = (plen_base < PW'(MAX_PATTERN));

  assign pfx_len = star_found ? star_pos : '0;
  assign suf_len = (plen == '0) ? '0 : (plen - PW'(1) - PW'(pfx_len));
  assign min_len = (plen == '0) ? '0 : LEN_W'(plen - PW'(1));
  assign name_len_inc = (name_len == NAME_LEN_MAX) ? name_len : (name_len + LEN_W'(1));
  assign pfx_check = (name_len < LEN_W'(pfx_len)) && (name_len < LEN_W'(plen))
                     && (name_len < LEN_W'(MAX_PATTERN));

  assign mismatch = chk && (chk_sym != chk_ref);
  assign prefix_ok_eff = prefix_ok && !(mismatch && !chk_last);

  always_ff @(posedge clk) begin
    if (pat_acc && store_en) begin
      pat_mem[plen_base[AW-1:0]] <= symbol;
    end
    if (name_acc) begin
      chk_ref <= pat_mem[name_len[AW-1:0]];
      chk_sym <= symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= '0;
      star_pos <= '0;
      star_found <= 1'b0;
      pattern_open <= 1'b0;
      name_len <= '0;
      prefix_ok <= 1'b1;
      chk <= 1'b0;
      chk_last <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (pat_acc) begin
        pattern_open <= !last;
        if (store_en) begin
          plen <= plen_base + PW'(1);
        end else begin
          plen <= plen_base;
        end
        if (store_en && (symbol == STAR_BYTE) && !star_base) begin
          star_found <= 1'b1;
          star_pos <= plen_base[AW-1:0];
        end else if (!pattern_open) begin
          star_found <= 1'b0;
          star_pos <= '0;
        end
      end
      if (name_acc) begin
        name_len <= last ? '0 : name_len_inc;
      end
      prefix_ok <= (name_acc && last) ? 1'b1 : prefix_ok_eff;
      chk <= name_acc && pfx_check;
      chk_last <= name_acc && last;
      s1_valid <= name_acc && last;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (name_acc && last) begin
      s1_pref <= prefix_ok_eff;
      s1_len_ok <= (name_len_inc >= min_len);
      s1_suf <= suf_len;
    end
    if (s1_valid) begin
      s2_base <= s1_pref && !mismatch && s1_len_ok;
    end
    if (s2_valid) begin
      s3_base <= s2_base;
      for (int g = 0; g < NG; g++) begin
        grp_ok[g] <= &ok_pad[g*GRP_W +: GRP_W];
      end
    end
  end

  assign cell_ctrl.pat_shift = pat_acc && store_en;
  assign cell_ctrl.name_shift = name_acc;
  assign cell_ctrl.capture = s1_valid;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    sym_t pat_in;
    sym_t name_in;

    if (j == 0) begin : g_head
      assign pat_in = symbol;
      assign name_in = symbol;
    end else begin : g_link
      assign pat_in = pat_chain[j-1];
      assign name_in = name_chain[j-1];
    end

    sgm_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .pat_in   (pat_in),
      .name_in  (name_in),
      .active   (s1_suf > PW'(j)),
      .pat_out  (pat_chain[j]),
      .name_out (name_chain[j]),
      .ok       (cell_ok[j])
    );
  end

  for (genvar i = 0; i < NG*GRP_W; i++) begin : g_pad
    if (i < MAX_PATTERN) begin : g_used
      assign ok_pad[i] = cell_ok[i];
    end else begin : g_fill
      assign ok_pad[i] = 1'b1;
    end
  end

  sgm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (s3_valid),
    .wr_data   (s3_base && (&grp_ok)),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .match     (match),
    .count     (fifo_count)
  );

endmodule
